// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, off while rst is high.
`define PPRM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on clk, checked during reset as well.
`define PPRM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/pprm_pkg.sv -----
// Types, constants and helpers of the page pool residency manager.
package pprm_pkg;

  localparam int POOL_SLOTS_DEF       = 16;
  localparam int REGION_PAGES_MAX_DEF = 1024;

  localparam int MODE_W     = 2;
  localparam int PAGE_W     = 10;
  localparam int STATUS_W   = 4;
  localparam int SLOT_OUT_W = 4;
  localparam int REGION_W   = 11;
  localparam int SEED_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [MODE_W-1:0] MODE_FAULT      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITEBACK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INVALIDATE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FLUSH      = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_FILL        = 4'd0;
  localparam logic [STATUS_W-1:0] STAT_EVICT_CLEAN = 4'd1;
  localparam logic [STATUS_W-1:0] STAT_EVICT_DIRTY = 4'd2;
  localparam logic [STATUS_W-1:0] STAT_OUTSIDE     = 4'd3;
  localparam logic [STATUS_W-1:0] STAT_WB_DONE     = 4'd4;
  localparam logic [STATUS_W-1:0] STAT_WB_SKIPPED  = 4'd5;
  localparam logic [STATUS_W-1:0] STAT_INVALIDATED = 4'd6;
  localparam logic [STATUS_W-1:0] STAT_NOT_RES     = 4'd7;
  localparam logic [STATUS_W-1:0] STAT_BAD_PAGE    = 4'd8;
  localparam logic [STATUS_W-1:0] STAT_FLUSH_WB    = 4'd9;
  localparam logic [STATUS_W-1:0] STAT_FLUSH_NONE  = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_PAGES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED  = 1'b1;

  localparam logic [REGION_W-1:0] REGION_RESET = 11'd1024;
  localparam logic [SEED_W-1:0]   DEFAULT_SEED = 16'd42;
  localparam logic [SEED_W-1:0]   LFSR_TAPS    = 16'hB400;

  typedef struct packed {
    logic              load;
    logic [SEED_W-1:0] seed;
    logic              start;
  } vic_ctrl_t;

  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] l);
    return l[0] ? ((l >> 1) ^ LFSR_TAPS) : (l >> 1);
  endfunction

endpackage

// ----- sv/pprm_ram.sv -----
// Single-port-write, registered-read memory.
module pprm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/pprm_victim.sv -----
// Victim chooser: LFSR step and reduction modulo the pool size.
module pprm_victim #(
  parameter int POOL_SLOTS = pprm_pkg::POOL_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pprm_pkg::vic_ctrl_t           ctrl,
  output logic                          done,
  output logic [$clog2(POOL_SLOTS)-1:0] victim
);
  import pprm_pkg::*;

  localparam int SW       = $clog2(POOL_SLOTS);
  localparam int RECIP_SH = SEED_W + SW;
  localparam int PROD_W   = 2 * SEED_W + 1;
  localparam bit IS_POW2  = (POOL_SLOTS == (1 << SW));
  localparam logic [SEED_W:0]   RECIP = (SEED_W + 1)'((1 << RECIP_SH) / POOL_SLOTS);
  localparam logic [SEED_W-1:0] DIV   = SEED_W'(POOL_SLOTS);

  logic [SEED_W-1:0] lfsr;
  logic [SEED_W-1:0] lfsr_next;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_sh;
  logic [SEED_W-1:0] quo;
  logic [SEED_W-1:0] qmul;
  logic [SEED_W-1:0] diff;
  logic [SEED_W-1:0] diff_sub;
  logic [SW-1:0]     rem;
  logic              busy;
  logic              phase;

  assign lfsr_next = lfsr_step(lfsr);
  assign prod      = PROD_W'(lfsr) * PROD_W'(RECIP);
  assign prod_sh   = prod >> RECIP_SH;
  assign qmul      = quo * DIV;
  assign diff      = lfsr - qmul;
  assign diff_sub  = diff - DIV;
  assign victim    = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr  <= DEFAULT_SEED;
      busy  <= 1'b0;
      phase <= 1'b0;
      done  <= 1'b0;
    end else begin
      if (ctrl.load) begin
        lfsr <= (ctrl.seed == '0) ? SEED_W'(1) : ctrl.seed;
        done <= 1'b0;
      end else if (ctrl.start) begin
        lfsr  <= lfsr_next;
        done  <= IS_POW2;
        busy  <= !IS_POW2;
        phase <= 1'b0;
      end else begin
        done  <= busy && phase;
        busy  <= busy && !phase;
        phase <= busy && !phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= lfsr_next[SW-1:0];
    end else if (busy) begin
      if (!phase) begin
        quo <= prod_sh[SEED_W-1:0];
      end else begin
        rem <= (diff >= DIV) ? diff_sub[SW-1:0] : diff[SW-1:0];
      end
    end
  end

endmodule

// ----- sv/page_pool_residency_manager.sv -----
// Page pool residency manager top level: request sequencer around the page and slot maps.
//
// Channels: a configuration write channel (cfg_valid/cfg_ready, cfg_index, cfg_data),
// always ready; index 0 sets the region size, index 1 sets random_seed and reloads the LFSR.
// Requests enter on req_valid/req_ready with mode, page and write_access; results
// leave on res_valid/res_ready with last set on the final result of each request.
// One request is worked at a time. Fault, writeback and invalidate are looked up in
// S_LOOK, which registers the result once the output register is free. A fault into
// a full pool goes on to S_MOD, where the modulo unit reduces the LFSR value (taking
// the low bits of a power-of-two pool), then S_VREAD, S_VDATA and S_VFILL, which
// registers its result. Flush walks the slots in S_FSCAN one a cycle while they are
// clean, steps to S_FEMIT for each dirty slot until its result is registered, and
// stops after the last dirty one. Both maps have registered reads: the page map is
// read at the page as the request is taken, the slot map at the victim or flushed slot.
// Reset clears all slots and then sweeps every page map entry, one entry a cycle,
// with req_ready low; configuration writes are taken meanwhile.
// A result waits in the output register while res_ready is low; the next request is
// still taken, but its result waits for the register to empty.
module page_pool_residency_manager #(
  parameter int POOL_SLOTS       = pprm_pkg::POOL_SLOTS_DEF,
  parameter int REGION_PAGES_MAX = pprm_pkg::REGION_PAGES_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pprm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pprm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [pprm_pkg::MODE_W-1:0]         mode,
  input  logic [pprm_pkg::PAGE_W-1:0]         page,
  input  logic                                write_access,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic [pprm_pkg::STATUS_W-1:0]       status,
  output logic [pprm_pkg::SLOT_OUT_W-1:0]     slot,
  output logic [pprm_pkg::PAGE_W-1:0]         victim_page,
  output logic                                victim_valid,
  output logic                                writeback_needed,
  output logic                                resident_warning,
  output logic                                last
);
  import pprm_pkg::*;

  localparam int SW      = $clog2(POOL_SLOTS);
  localparam int PAW     = $clog2(REGION_PAGES_MAX);
  localparam int PEW     = SW + 1;
  localparam int LIM_RAW = $clog2(REGION_PAGES_MAX + 1);
  localparam int LW      = (LIM_RAW > REGION_W) ? LIM_RAW : REGION_W;
  localparam logic [LW-1:0]  LIM_MAX   = LW'(REGION_PAGES_MAX);
  localparam logic [SW-1:0]  SLOT_LAST = SW'(POOL_SLOTS - 1);
  localparam logic [PAW-1:0] ADDR_LAST = PAW'(REGION_PAGES_MAX - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_MOD   = 4'd3;
  localparam logic [3:0] S_VREAD = 4'd4;
  localparam logic [3:0] S_VDATA = 4'd5;
  localparam logic [3:0] S_VFILL = 4'd6;
  localparam logic [3:0] S_FSCAN = 4'd7;
  localparam logic [3:0] S_FEMIT = 4'd8;

  logic [3:0]            state;
  logic [3:0]            state_next;
  logic [PAW-1:0]        clr_idx;
  logic [REGION_W-1:0]   region_size;
  logic [POOL_SLOTS-1:0] used;
  logic [POOL_SLOTS-1:0] dirty;
  logic [MODE_W-1:0]     cur_mode;
  logic [PAGE_W-1:0]     cur_page;
  logic                  cur_wr;
  logic [SW-1:0]         fidx;
  logic [SW-1:0]         vslot;
  logic [PAGE_W-1:0]     vpage;

  logic                  pm_we;
  logic [PAW-1:0]        pm_waddr;
  logic [PEW-1:0]        pm_wdata;
  logic [PAW-1:0]        pm_raddr;
  logic [PEW-1:0]        pm_rdata;
  logic                  sm_we;
  logic [SW-1:0]         sm_waddr;
  logic [PAGE_W-1:0]     sm_wdata;
  logic [SW-1:0]         sm_raddr;
  logic [PAGE_W-1:0]     sm_rdata;

  vic_ctrl_t             vic_ctrl;
  logic                  vic_start;
  logic                  vic_done;
  logic [SW-1:0]         vic_slot;

  logic                  used_we;
  logic [SW-1:0]         used_slot;
  logic                  used_val;
  logic                  dirty_we;
  logic [SW-1:0]         dirty_slot;
  logic                  dirty_val;

  logic                  emit;
  logic [STATUS_W-1:0]   e_status;
  logic [SW-1:0]         e_slot;
  logic [PAGE_W-1:0]     e_vpage;
  logic                  e_vvalid;
  logic                  e_wb;
  logic                  e_warn;
  logic                  e_last;

  logic                  out_free;
  logic                  accept;
  logic [LW-1:0]         lim;
  logic                  page_ok;
  logic                  hit;
  logic [SW-1:0]         hslot;
  logic [SW-1:0]         free_slot;
  logic                  full;
  logic [POOL_SLOTS-1:0] hd;
  logic                  more;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !res_valid || res_ready;

  assign pm_raddr = (state == S_IDLE) ? PAW'(page) : PAW'(cur_page);
  assign sm_raddr = ((state == S_FSCAN) || (state == S_FEMIT)) ? fidx : vslot;

  assign lim     = (LW'(region_size) < LIM_MAX) ? LW'(region_size) : LIM_MAX;
  assign page_ok = (LW'(cur_page) < lim);
  assign hit     = pm_rdata[SW];
  assign hslot   = pm_rdata[SW-1:0];
  assign full    = &used;
  assign hd      = used & dirty;

  assign vic_ctrl.load  = cfg_valid && cfg_ready && (cfg_index == CFG_RANDOM_SEED);
  assign vic_ctrl.seed  = cfg_data[SEED_W-1:0];
  assign vic_ctrl.start = vic_start;

  always_comb begin
    free_slot = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_slot = SW'(i);
      end
    end
  end

  always_comb begin
    more = 1'b0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      if ((SW'(i) > fidx) && hd[i]) begin
        more = 1'b1;
      end
    end
  end

  pprm_ram #(
    .DEPTH (REGION_PAGES_MAX),
    .WIDTH (PEW)
  ) u_page_map (
    .clk     (clk),
    .wr_en   (pm_we),
    .wr_addr (pm_waddr),
    .wr_data (pm_wdata),
    .rd_addr (pm_raddr),
    .rd_data (pm_rdata)
  );

  pprm_ram #(
    .DEPTH (POOL_SLOTS),
    .WIDTH (PAGE_W)
  ) u_slot_map (
    .clk     (clk),
    .wr_en   (sm_we),
    .wr_addr (sm_waddr),
    .wr_data (sm_wdata),
    .rd_addr (sm_raddr),
    .rd_data (sm_rdata)
  );

  pprm_victim #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_victim (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (vic_ctrl),
    .done   (vic_done),
    .victim (vic_slot)
  );

  always_comb begin
    state_next = state;
    pm_we      = 1'b0;
    pm_waddr   = PAW'(cur_page);
    pm_wdata   = '0;
    sm_we      = 1'b0;
    sm_waddr   = vslot;
    sm_wdata   = cur_page;
    vic_start  = 1'b0;
    used_we    = 1'b0;
    used_slot  = hslot;
    used_val   = 1'b0;
    dirty_we   = 1'b0;
    dirty_slot = hslot;
    dirty_val  = 1'b0;
    emit       = 1'b0;
    e_status   = STAT_FILL;
    e_slot     = '0;
    e_vpage    = '0;
    e_vvalid   = 1'b0;
    e_wb       = 1'b0;
    e_warn     = 1'b0;
    e_last     = 1'b1;
    case (state)
      S_CLEAR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_idx;
        if (clr_idx == ADDR_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          state_next = (mode == MODE_FLUSH) ? S_FSCAN : S_LOOK;
        end
      end
      S_LOOK: begin
        if (cur_mode == MODE_FAULT) begin
          if (!page_ok) begin
            e_status = STAT_OUTSIDE;
            emit     = out_free;
          end else if (hit) begin
            e_slot    = hslot;
            e_warn    = 1'b1;
            emit      = out_free;
            dirty_we  = out_free;
            dirty_val = dirty[hslot] | cur_wr;
          end else if (!full) begin
            e_slot     = free_slot;
            emit       = out_free;
            pm_we      = out_free;
            pm_wdata   = {1'b1, free_slot};
            sm_we      = out_free;
            sm_waddr   = free_slot;
            used_we    = out_free;
            used_slot  = free_slot;
            used_val   = 1'b1;
            dirty_we   = out_free;
            dirty_slot = free_slot;
            dirty_val  = cur_wr;
          end else begin
            vic_start  = 1'b1;
            state_next = S_MOD;
          end
        end else begin
          if (!page_ok) begin
            e_status = STAT_BAD_PAGE;
            emit     = out_free;
          end else if (!hit) begin
            e_status = STAT_NOT_RES;
            emit     = out_free;
          end else begin
            e_slot   = hslot;
            e_vpage  = cur_page;
            e_vvalid = 1'b1;
            emit     = out_free;
            if (cur_mode == MODE_INVALIDATE) begin
              e_status = STAT_INVALIDATED;
              pm_we    = out_free;
              used_we  = out_free;
              dirty_we = out_free;
            end else if (dirty[hslot]) begin
              e_status = STAT_WB_DONE;
              e_wb     = 1'b1;
              dirty_we = out_free;
            end else begin
              e_status = STAT_WB_SKIPPED;
            end
          end
        end
        if (emit) begin
          state_next = S_IDLE;
        end
      end
      S_MOD: begin
        if (vic_done) begin
          state_next = S_VREAD;
        end
      end
      S_VREAD: begin
        state_next = S_VDATA;
      end
      S_VDATA: begin
        pm_we      = 1'b1;
        pm_waddr   = PAW'(sm_rdata);
        state_next = S_VFILL;
      end
      S_VFILL: begin
        e_status   = dirty[vslot] ? STAT_EVICT_DIRTY : STAT_EVICT_CLEAN;
        e_slot     = vslot;
        e_vpage    = vpage;
        e_vvalid   = 1'b1;
        e_wb       = dirty[vslot];
        emit       = out_free;
        pm_we      = out_free;
        pm_wdata   = {1'b1, vslot};
        sm_we      = out_free;
        dirty_we   = out_free;
        dirty_slot = vslot;
        dirty_val  = cur_wr;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_FSCAN: begin
        if (hd[fidx]) begin
          state_next = S_FEMIT;
        end else if (fidx == SLOT_LAST) begin
          e_status = STAT_FLUSH_NONE;
          emit     = out_free;
          if (out_free) begin
            state_next = S_IDLE;
          end
        end
      end
      S_FEMIT: begin
        e_status   = STAT_FLUSH_WB;
        e_slot     = fidx;
        e_vpage    = sm_rdata;
        e_vvalid   = 1'b1;
        e_wb       = 1'b1;
        e_last     = !more;
        emit       = out_free;
        dirty_we   = out_free;
        dirty_slot = fidx;
        if (out_free) begin
          state_next = more ? S_FSCAN : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      region_size <= REGION_RESET;
      used        <= '0;
      dirty       <= '0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + PAW'(1);
      end
      if (cfg_valid && cfg_ready && (cfg_index == CFG_REGION_PAGES)) begin
        region_size <= cfg_data[REGION_W-1:0];
      end
      if (used_we) begin
        used[used_slot] <= used_val;
      end
      if (dirty_we) begin
        dirty[dirty_slot] <= dirty_val;
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_mode <= mode;
      cur_page <= page;
      cur_wr   <= write_access;
      fidx     <= '0;
    end else if ((state == S_FSCAN) && !hd[fidx] && (fidx != SLOT_LAST)) begin
      fidx <= fidx + SW'(1);
    end else if ((state == S_FEMIT) && out_free) begin
      fidx <= fidx + SW'(1);
    end
    if (vic_done) begin
      vslot <= vic_slot;
    end
    if (state == S_VDATA) begin
      vpage <= sm_rdata;
    end
    if (emit) begin
      status           <= e_status;
      slot             <= SLOT_OUT_W'(e_slot);
      victim_page      <= e_vpage;
      victim_valid     <= e_vvalid;
      writeback_needed <= e_wb;
      resident_warning <= e_warn;
      last             <= e_last;
    end
  end

endmodule

// ----- sv/pprm_checker.sv -----
// Port-level checker of the page pool residency manager and its bind.
`include "assert_macros.svh"

module pprm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [pprm_pkg::STATUS_W-1:0]   status,
  input logic [pprm_pkg::SLOT_OUT_W-1:0] slot,
  input logic [pprm_pkg::PAGE_W-1:0]     victim_page,
  input logic                            victim_valid,
  input logic                            writeback_needed,
  input logic                            last
);

  `PPRM_ASSERT_ALWAYS(a_reset_quiet, rst |=> !res_valid && !req_ready, "busy after reset")

  `PPRM_ASSERT_RST(a_one_item, req_valid && req_ready |=> !req_ready, "second item taken")

  `PPRM_ASSERT_RST(a_busy_mid_list, res_valid && !last |-> !req_ready, "ready before last result")

  `PPRM_ASSERT_RST(a_no_victim_page, res_valid && !victim_valid |-> victim_page == '0 && !writeback_needed, "victim fields set without victim")

  `PPRM_ASSERT_RST(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(status) && $stable(slot), "stalled result changed")

endmodule

bind page_pool_residency_manager pprm_checker u_pprm_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the page pool residency manager: directed and random requests.
module testbench;
  import pprm_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 5000;
  localparam int SLOT_IDX_W    = $clog2(POOL_SLOTS_DEF);

  typedef enum logic [1:0] {JOB_REQUEST, JOB_REGISTER, JOB_DRAIN, JOB_IDLING} job_kind_t;

  typedef struct packed {
    job_kind_t             kind;
    logic [MODE_W-1:0]     req_mode;
    logic [PAGE_W-1:0]     req_page;
    logic                  req_write;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;
    logic [6:0]            send_pct;
    logic [6:0]            recv_pct;
  } job_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [PAGE_W-1:0]     victim_page;
    logic                  victim_valid;
    logic                  writeback_needed;
    logic                  resident_warning;
    logic                  last;
  } result_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  req_valid    = 1'b0;
  logic                  req_ready;
  logic [MODE_W-1:0]     mode         = '0;
  logic [PAGE_W-1:0]     page         = '0;
  logic                  write_access = 1'b0;
  logic                  res_valid;
  logic                  res_ready    = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] slot;
  logic [PAGE_W-1:0]     victim_page;
  logic                  victim_valid;
  logic                  writeback_needed;
  logic                  resident_warning;
  logic                  last;

  job_t    pending_requests[$];
  result_t expected_results[$];
  int      mismatch_count = 0;
  int      stall_cycles   = 0;
  int      drain_count    = 0;
  int      send_idle_pct  = 0;
  int      recv_idle_pct  = 0;

  logic [REGION_W-1:0]   region_size_cfg;
  logic [SEED_W-1:0]     victim_lfsr;
  logic                  page_present [REGION_PAGES_MAX_DEF];
  logic [SLOT_IDX_W-1:0] page_slot    [REGION_PAGES_MAX_DEF];
  logic                  slot_used    [POOL_SLOTS_DEF];
  logic [PAGE_W-1:0]     slot_page    [POOL_SLOTS_DEF];
  logic                  slot_modified [POOL_SLOTS_DEF];

  page_pool_residency_manager DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready),
    .mode(mode), .page(page), .write_access(write_access),
    .res_valid(res_valid), .res_ready(res_ready),
    .status(status), .slot(slot), .victim_page(victim_page), .victim_valid(victim_valid),
    .writeback_needed(writeback_needed), .resident_warning(resident_warning), .last(last)
  );

  initial forever #5 clk = ~clk;

  function automatic void clear_residency();
    int i;
    region_size_cfg = REGION_RESET;
    victim_lfsr = DEFAULT_SEED;
    for (i = 0; i < REGION_PAGES_MAX_DEF; i++) begin
      page_present[i] = 1'b0;
      page_slot[i] = '0;
    end
    for (i = 0; i < POOL_SLOTS_DEF; i++) begin
      slot_used[i] = 1'b0;
      slot_page[i] = '0;
      slot_modified[i] = 1'b0;
    end
  endfunction

  function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_REGION_PAGES) begin
      region_size_cfg = data[REGION_W-1:0];
    end else begin
      victim_lfsr = (data[SEED_W-1:0] == '0) ? 16'd1 : data[SEED_W-1:0];
    end
  endfunction

  function automatic void predict_residency(input logic [MODE_W-1:0] m,
                                            input logic [PAGE_W-1:0] pg, input logic wr);
    logic [REGION_W-1:0]   usable;
    logic [SLOT_IDX_W-1:0] s;
    logic                  found;
    result_t               r;
    result_t               held;
    int                    i;
    usable = region_size_cfg;
    if (usable > REGION_PAGES_MAX_DEF) usable = REGION_W'(REGION_PAGES_MAX_DEF);
    r = '0;
    r.last = 1'b1;
    held = '0;
    found = 1'b0;
    s = '0;
    case (m)
      MODE_FAULT: begin
        if ({1'b0, pg} >= usable) begin
          r.status = STAT_OUTSIDE;
        end else if (page_present[pg]) begin
          s = page_slot[pg];
          slot_modified[s] = slot_modified[s] | wr;
          r.status = STAT_FILL;
          r.slot = s;
          r.resident_warning = 1'b1;
        end else begin
          for (i = 0; i < POOL_SLOTS_DEF; i++) begin
            if (!found && !slot_used[i]) begin
              found = 1'b1;
              s = SLOT_IDX_W'(i);
            end
          end
          if (found) begin
            r.status = STAT_FILL;
          end else begin
            victim_lfsr = {1'b0, victim_lfsr[SEED_W-1:1]} ^ (victim_lfsr[0] ? LFSR_TAPS : '0);
            s = SLOT_IDX_W'(victim_lfsr % POOL_SLOTS_DEF);
            r.status = slot_modified[s] ? STAT_EVICT_DIRTY : STAT_EVICT_CLEAN;
            r.victim_page = slot_page[s];
            r.victim_valid = 1'b1;
            r.writeback_needed = slot_modified[s];
            page_present[slot_page[s]] = 1'b0;
          end
          slot_used[s] = 1'b1;
          slot_page[s] = pg;
          slot_modified[s] = wr;
          page_present[pg] = 1'b1;
          page_slot[pg] = s;
          r.slot = s;
        end
      end
      MODE_WRITEBACK, MODE_INVALIDATE: begin
        if ({1'b0, pg} >= usable) begin
          r.status = STAT_BAD_PAGE;
        end else if (!page_present[pg]) begin
          r.status = STAT_NOT_RES;
        end else begin
          s = page_slot[pg];
          r.slot = s;
          r.victim_page = pg;
          r.victim_valid = 1'b1;
          if (m == MODE_INVALIDATE) begin
            page_present[pg] = 1'b0;
            slot_used[s] = 1'b0;
            slot_page[s] = '0;
            slot_modified[s] = 1'b0;
            r.status = STAT_INVALIDATED;
          end else if (slot_modified[s]) begin
            slot_modified[s] = 1'b0;
            r.status = STAT_WB_DONE;
            r.writeback_needed = 1'b1;
          end else begin
            r.status = STAT_WB_SKIPPED;
          end
        end
      end
      default: begin
        for (i = 0; i < POOL_SLOTS_DEF; i++) begin
          if (slot_used[i] && slot_modified[i]) begin
            if (found) expected_results.push_back(held);
            slot_modified[i] = 1'b0;
            held = '0;
            held.status = STAT_FLUSH_WB;
            held.slot = SLOT_OUT_W'(i);
            held.victim_page = slot_page[i];
            held.victim_valid = 1'b1;
            held.writeback_needed = 1'b1;
            found = 1'b1;
          end
        end
        if (found) begin
          held.last = 1'b1;
          r = held;
        end else begin
          r.status = STAT_FLUSH_NONE;
        end
      end
    endcase
    expected_results.push_back(r);
  endfunction

  function automatic void add_request(input logic [MODE_W-1:0] m, input logic [PAGE_W-1:0] pg,
                                      input logic wr);
    job_t job;
    job = '0;
    job.kind = JOB_REQUEST;
    job.req_mode = m;
    job.req_page = pg;
    job.req_write = wr;
    pending_requests.push_back(job);
  endfunction

  function automatic void add_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    job_t job;
    job = '0;
    job.kind = JOB_REGISTER;
    job.reg_index = idx;
    job.reg_data = data;
    pending_requests.push_back(job);
  endfunction

  function automatic void add_settings(input int region, input int seed);
    job_t job;
    job = '0;
    job.kind = JOB_DRAIN;
    pending_requests.push_back(job);
    add_register(CFG_REGION_PAGES, CFG_DATA_W'(region));
    add_register(CFG_RANDOM_SEED, CFG_DATA_W'(seed));
  endfunction

  function automatic void add_idling(input int send, input int recv);
    job_t job;
    job = '0;
    job.kind = JOB_IDLING;
    job.send_pct = 7'(send);
    job.recv_pct = 7'(recv);
    pending_requests.push_back(job);
  endfunction

  function automatic void add_random_request(input int region, input int base);
    int                pick;
    int                pg;
    logic [MODE_W-1:0] m;
    pick = $urandom_range(0, 99);
    if (pick < 65) pg = base + $urandom_range(0, 23);
    else if (pick < 85) pg = $urandom_range(0, 1023);
    else pg = region - 2 + $urandom_range(0, 3);
    if (pg < 0) pg = 0;
    if (pg > 1023) pg = 1023;
    pick = $urandom_range(0, 99);
    if (pick < 50) m = MODE_FAULT;
    else if (pick < 72) m = MODE_WRITEBACK;
    else if (pick < 88) m = MODE_INVALIDATE;
    else m = MODE_FLUSH;
    add_request(m, PAGE_W'(pg), 1'($urandom_range(0, 1)));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    logic req_next;
    logic cfg_next;
    job_t job;
    if (rst) begin
      clear_residency();
      drain_count = 0;
      req_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) predict_residency(mode, page, write_access);
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      req_next = req_valid && !req_ready;
      cfg_next = cfg_valid && !cfg_ready;
      if (!req_next && !cfg_next && pending_requests.size() != 0) begin
        job = pending_requests[0];
        case (job.kind)
          JOB_REQUEST: begin
            if ($urandom_range(0, 99) >= send_idle_pct) begin
              mode <= job.req_mode;
              page <= job.req_page;
              write_access <= job.req_write;
              req_next = 1'b1;
              pending_requests.delete(0);
            end
          end
          JOB_REGISTER: begin
            cfg_index <= job.reg_index;
            cfg_data <= job.reg_data;
            cfg_next = 1'b1;
            pending_requests.delete(0);
          end
          JOB_DRAIN: begin
            // hold off until the block has gone quiet
            drain_count = (expected_results.size() == 0) ? drain_count + 1 : 0;
            if (drain_count >= SETTLE_CYCLES) begin
              drain_count = 0;
              pending_requests.delete(0);
            end
          end
          default: begin
            send_idle_pct = job.send_pct;
            recv_idle_pct <= job.recv_pct;
            pending_requests.delete(0);
          end
        endcase
      end
      req_valid <= req_next;
      cfg_valid <= cfg_next;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          if (slot !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", slot, want.slot));
          if (victim_page !== want.victim_page)
            report_mismatch($sformatf("victim_page %0d, expected %0d",
                                      victim_page, want.victim_page));
          if (victim_valid !== want.victim_valid)
            report_mismatch($sformatf("victim_valid %b, expected %b",
                                      victim_valid, want.victim_valid));
          if (writeback_needed !== want.writeback_needed)
            report_mismatch($sformatf("writeback_needed %b, expected %b",
                                      writeback_needed, want.writeback_needed));
          if (resident_warning !== want.resident_warning)
            report_mismatch($sformatf("resident_warning %b, expected %b",
                                      resident_warning, want.resident_warning));
          if (last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", last, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int region;
    int base;
    int k;
    add_idling(23, 66);
    add_settings(1024, 65535);
    add_request(MODE_FLUSH, 0, 0);
    add_request(MODE_WRITEBACK, 5, 0);
    add_request(MODE_FAULT, 0, 0);
    add_request(MODE_FAULT, 0, 1);
    add_request(MODE_WRITEBACK, 0, 0);
    add_request(MODE_WRITEBACK, 0, 0);
    add_request(MODE_FAULT, 1023, 1);
    add_request(MODE_FLUSH, 0, 0);
    add_request(MODE_INVALIDATE, 1023, 0);
    for (k = 0; k < 15; k++) add_request(MODE_FAULT, PAGE_W'(100 + k), k[0]);
    add_request(MODE_FAULT, 200, 1);
    add_request(MODE_FLUSH, 1023, 1);
    // shrink the region under resident pages and load a zero seed
    add_settings(1, 0);
    add_request(MODE_INVALIDATE, 0, 1);
    add_request(MODE_FAULT, 0, 1);
    add_request(MODE_FAULT, 1, 0);
    add_request(MODE_WRITEBACK, 1023, 0);
    add_request(MODE_INVALIDATE, 114, 0);
    add_request(MODE_FLUSH, 0, 0);
    for (k = 0; k < 6; k++) begin
      if (k == 2) add_idling(66, 23);
      if (k == 4) add_idling(0, 0);
      if (k == 0) region = 1024;
      else if (k == 1) region = $urandom_range(2, 40);
      else if ($urandom_range(0, 1) == 1) region = 1024;
      else region = $urandom_range(25, 1023);
      add_settings(region, (k == 0) ? 1 : $urandom_range(1, 65535));
      base = $urandom_range(0, (region > 24) ? region - 24 : 0);
      repeat (36) add_random_request(region, base);
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_requests.size() != 0 || req_valid || cfg_valid ||
           expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/pprm_pkg.sv
sv/pprm_ram.sv
sv/pprm_victim.sv
sv/page_pool_residency_manager.sv
sv/pprm_checker.sv
tb/testbench.sv
